// ----- rtl/bssta_pkg.sv -----
// Shared types, codes and constants of the beacon table with aging.
package bssta_pkg;

    localparam int unsigned DEF_SLOTS        = 64;
    localparam logic [31:0] EXPIRY_RESET     = 32'd1000;
    localparam logic [31:0] PRUNE_DLY_RESET  = 32'd100;

    localparam logic CFG_EXPIRY    = 1'b0;
    localparam logic CFG_PRUNE_DLY = 1'b1;

    localparam logic [1:0] ST_RENEWED = 2'd0;
    localparam logic [1:0] ST_UPDATED = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;

    // Bit positions within the receive flags of a beacon.
    localparam int unsigned RXF_RADIO = 0;
    localparam int unsigned RXF_RSSI  = 1;
    localparam int unsigned RXF_RCPI  = 2;
    localparam int unsigned RXF_SNR   = 3;

    typedef struct packed {
        logic [47:0] key;
        logic [31:0] refreshed;
        logic [63:0] sync_time;
        logic [11:0] length;
        logic [31:0] signature;
        logic [15:0] interval;
        logic [15:0] capability;
        logic [7:0]  channel;
        logic [7:0]  rssi;
        logic [7:0]  rcpi;
        logic [7:0]  snr;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRUNE,
        S_DECIDE,
        S_SEARCH,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

// ----- rtl/bss_table_upsert_with_aging_top.sv -----
// Top level of the beacon table: keyed lookup, insert and aging prune over one slot memory.
//
//  channel  direction  handshake                    payload
//  in       to block   i_in_valid / o_in_stall      one beacon request, one port per field
//  out      from block i_out_stall / o_out_valid    one result request, one port per field
//  cfg      to block   i_cfg_valid / o_cfg_ready    register index and 32-bit write data
//
// When the table has room, a beacon takes one pass over the slot memory to find the key
// or the lowest free slot, then one write-back; the pass ends early when the key turns up.
// A full table triggers a prune pass first, or is refused without one. The single read
// port of the slot memory, one entry per cycle, sets the pace of each pass.
// Reset is synchronous and active low; it clears the valid bits, the fill count and the
// last prune time, so no clearing pass is needed. A stalled result sits in the output
// register while the next beacon is already accepted and worked on.
module bss_table_upsert_with_aging_top
    import bssta_pkg::*;
#(
    parameter int unsigned SLOTS = DEF_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [47:0] i_bss_id,
    input  logic [31:0] i_now_ticks,
    input  logic [63:0] i_sync_timestamp,
    input  logic [11:0] i_frame_length,
    input  logic [31:0] i_frame_signature,
    input  logic [15:0] i_interval_field,
    input  logic [15:0] i_capability_field,
    input  logic [3:0]  i_rx_flags,
    input  logic [7:0]  i_rx_channel,
    input  logic signed [7:0] i_rssi_value,
    input  logic [7:0]  i_rcpi_value,
    input  logic [7:0]  i_snr_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_slot_index,
    output logic        o_new_entry,
    output logic        o_known_changed,
    output logic [6:0]  o_pruned_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

    // Slot memory with one registered read port and one write port.
    t_slot   r_mem [SLOTS];
    t_slot   r_rd;
    logic [SW-1:0] rd_addr;
    logic          mem_we;
    t_slot         mem_wd;

    t_state r_state, n_state;

    logic [SLOTS-1:0] r_valid;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_pruned;
    logic [31:0]      r_last_prune, r_expiry, r_prune_dly;

    // Latched beacon fields, held until the entry is written back.
    logic [47:0] r_key;
    logic [31:0] r_now;
    logic [63:0] r_ts;
    logic [11:0] r_len;
    logic [31:0] r_sig;
    logic [15:0] r_ivl, r_cap;
    logic [3:0]  r_flags;
    logic [7:0]  r_chan, r_rssi, r_rcpi, r_snr;

    // Memory walk: issue address, and check stage in the cycle after the issue.
    logic [SW-1:0] r_idx, r_chk_idx;
    logic          r_issue_done, r_chk_v;
    logic          r_free_found;
    logic [SW-1:0] r_free;

    // Stored fields of the target slot; zero when the slot is being inserted.
    logic [SW-1:0] r_slot;
    logic          r_hit, r_new;
    logic [11:0]   r_old_len;
    logic [31:0]   r_old_sig;
    logic [15:0]   r_old_ivl, r_old_cap;
    logic [7:0]    r_old_chan, r_old_rssi, r_old_rcpi, r_old_snr;
    logic          r_refuse;

    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [5:0]    r_out_slot;
    logic          r_out_new, r_out_known;
    logic [6:0]    r_out_pruned;

    logic in_acc, full, elapsed, chk_last, chk_match, aged, out_free, changed;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign full      = (r_count == FULL_CNT);
    assign elapsed   = ((i_now_ticks - r_last_prune) >= r_prune_dly);
    assign chk_last  = r_chk_v && (r_chk_idx == LAST_IDX);
    assign chk_match = r_chk_v && r_valid[r_chk_idx] && (r_rd.key == r_key);
    assign aged      = r_chk_v && r_valid[r_chk_idx] && ((r_now - r_rd.refreshed) > r_expiry);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign changed   = (r_len != r_old_len) || (r_sig != r_old_sig);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= mem_wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!full)        n_state = S_SEARCH;
                    else if (elapsed) n_state = S_PRUNE;
                    else              n_state = S_DONE;
                end
            end
            S_PRUNE:  if (chk_last) n_state = S_DECIDE;
            S_DECIDE: n_state = full ? S_DONE : S_SEARCH;
            S_SEARCH: if (chk_match || chk_last) n_state = S_UPDATE;
            S_UPDATE: n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer. Channel and measurements change only when radio info is
    // present; interval and capability follow a changed length or signature.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        o_cfg_ready = 1'b1;
        rd_addr    = r_idx;
        mem_we     = (r_state == S_UPDATE);
        mem_wd.key        = r_key;
        mem_wd.refreshed  = r_now;
        mem_wd.sync_time  = r_ts;
        mem_wd.length     = changed ? r_len : r_old_len;
        mem_wd.signature  = changed ? r_sig : r_old_sig;
        mem_wd.interval   = changed ? r_ivl : r_old_ivl;
        mem_wd.capability = changed ? r_cap : r_old_cap;
        mem_wd.channel    = r_flags[RXF_RADIO] ? r_chan : r_old_chan;
        mem_wd.rssi       = (r_flags[RXF_RADIO] && r_flags[RXF_RSSI]) ? r_rssi : r_old_rssi;
        mem_wd.rcpi       = (r_flags[RXF_RADIO] && r_flags[RXF_RCPI]) ? r_rcpi : r_old_rcpi;
        mem_wd.snr        = (r_flags[RXF_RADIO] && r_flags[RXF_SNR]) ? r_snr : r_old_snr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_count      <= '0;
            r_last_prune <= '0;
            r_expiry     <= EXPIRY_RESET;
            r_prune_dly  <= PRUNE_DLY_RESET;
            r_chk_v      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_EXPIRY:    r_expiry    <= i_cfg_data;
                    CFG_PRUNE_DLY: r_prune_dly <= i_cfg_data;
                    default:       r_expiry    <= r_expiry;
                endcase
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // The walk issues one address a cycle and checks each one in the cycle after.
            if ((r_state == S_PRUNE || r_state == S_SEARCH) && !r_issue_done) begin
                r_chk_v   <= 1'b1;
                r_chk_idx <= r_idx;
                r_idx     <= r_idx + 1'b1;
                if (r_idx == LAST_IDX) r_issue_done <= 1'b1;
            end else begin
                r_chk_v <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_key        <= i_bss_id;
                        r_now        <= i_now_ticks;
                        r_ts         <= i_sync_timestamp;
                        r_len        <= i_frame_length;
                        r_sig        <= i_frame_signature;
                        r_ivl        <= i_interval_field;
                        r_cap        <= i_capability_field;
                        r_flags      <= i_rx_flags;
                        r_chan       <= i_rx_channel;
                        r_rssi       <= i_rssi_value;
                        r_rcpi       <= i_rcpi_value;
                        r_snr        <= i_snr_value;
                        r_idx        <= '0;
                        r_issue_done <= 1'b0;
                        r_free_found <= 1'b0;
                        r_free       <= '0;
                        r_hit        <= 1'b0;
                        r_pruned     <= '0;
                        r_refuse     <= full && !elapsed;
                        if (full && elapsed) r_last_prune <= i_now_ticks;
                    end
                end
                S_PRUNE: begin
                    if (aged) begin
                        r_valid[r_chk_idx] <= 1'b0;
                        r_count  <= r_count - 1'b1;
                        r_pruned <= r_pruned + 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_idx        <= '0;
                    r_issue_done <= 1'b0;
                    r_refuse     <= full;
                end
                S_SEARCH: begin
                    if (r_chk_v && !r_valid[r_chk_idx] && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free       <= r_chk_idx;
                    end
                    if (chk_match) begin
                        r_hit      <= 1'b1;
                        r_slot     <= r_chk_idx;
                        r_old_len  <= r_rd.length;
                        r_old_sig  <= r_rd.signature;
                        r_old_ivl  <= r_rd.interval;
                        r_old_cap  <= r_rd.capability;
                        r_old_chan <= r_rd.channel;
                        r_old_rssi <= r_rd.rssi;
                        r_old_rcpi <= r_rd.rcpi;
                        r_old_snr  <= r_rd.snr;
                    end else if (chk_last) begin
                        // No match: insert into the lowest free slot, fields start at zero.
                        r_slot     <= (r_free_found || r_valid[r_chk_idx]) ? r_free : r_chk_idx;
                        r_old_len  <= '0;
                        r_old_sig  <= '0;
                        r_old_ivl  <= '0;
                        r_old_cap  <= '0;
                        r_old_chan <= '0;
                        r_old_rssi <= '0;
                        r_old_rcpi <= '0;
                        r_old_snr  <= '0;
                    end
                end
                S_UPDATE: begin
                    r_new <= !r_hit;
                    if (!r_hit) begin
                        r_valid[r_slot] <= 1'b1;
                        r_count <= r_count + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_pruned <= 7'(r_pruned);
                        if (r_refuse) begin
                            r_out_status <= ST_NO_SLOT;
                            r_out_slot   <= '0;
                            r_out_new    <= 1'b0;
                            r_out_known  <= 1'b0;
                        end else begin
                            r_out_status <= changed ? ST_UPDATED : ST_RENEWED;
                            r_out_slot   <= 6'(r_slot);
                            r_out_new    <= r_new;
                            r_out_known  <= changed && (r_old_len != '0);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot_index    = r_out_slot;
    assign o_new_entry     = r_out_new;
    assign o_known_changed = r_out_known;
    assign o_pruned_count  = r_out_pruned;

endmodule
